// ===== rtl/core/clcd_pkg.sv =====
package clcd_pkg;

  // Field widths
  localparam int unsigned DdrAw   = 7;
  localparam int unsigned CgrAw   = 6;
  localparam int unsigned DataW   = 8;
  localparam int unsigned ShiftW  = 6;
  localparam int unsigned DdrDepth = 1 << DdrAw;

  // Item modes
  localparam logic [1:0] MODE_DATA = 2'd0;
  localparam logic [1:0] MODE_CMD  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // Command bits, highest set bit wins
  localparam int unsigned CMD_SET_DDRAM = 7;
  localparam int unsigned CMD_SET_CGRAM = 6;
  localparam int unsigned CMD_FUNC_SET  = 5;
  localparam int unsigned CMD_SHIFT     = 4;
  localparam int unsigned CMD_DISP_CTRL = 3;
  localparam int unsigned CMD_ENTRY     = 2;
  localparam int unsigned CMD_HOME      = 1;
  localparam int unsigned CMD_CLEAR     = 0;

  // Request from the control logic to the display memory
  typedef struct packed {
    logic              clr;
    logic              wr_en;
    logic [DdrAw-1:0]  wr_addr;
    logic [DataW-1:0]  wr_data;
    logic              rd_en;
    logic [DdrAw-1:0]  rd_addr;
  } ddr_req_t;

  // DDRAM address of the first column of each row
  function automatic logic [DdrAw-1:0] row_base(input logic [1:0] row);
    logic [DdrAw-1:0] base;
    unique case (row)
      2'd0:    base = 7'h00;
      2'd1:    base = 7'h40;
      2'd2:    base = 7'h14;
      default: base = 7'h54;
    endcase
    return base;
  endfunction

endpackage

// ===== rtl/core/clcd_in_if.sv =====
interface clcd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] value;
  logic [4:0] cell_col;
  logic [1:0] cell_row;

  modport source (output valid, mode, value, cell_col, cell_row, input ready);
  modport sink   (input valid, mode, value, cell_col, cell_row, output ready);
endinterface

// ===== rtl/core/clcd_out_if.sv =====
interface clcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_char;
  logic [6:0] address_counter;
  logic       glyph_write_active;
  logic [5:0] glyph_address;
  logic [5:0] display_offset;
  logic       display_enabled;
  logic       cursor_enabled;
  logic       blink_enabled;
  logic       increment_dir;
  logic       bus_eight_bit;
  logic       two_line;
  logic       tall_font;

  modport source (output valid, cell_char, address_counter, glyph_write_active,
                  glyph_address, display_offset, display_enabled, cursor_enabled,
                  blink_enabled, increment_dir, bus_eight_bit, two_line, tall_font,
                  input ready);
  modport sink   (input valid, cell_char, address_counter, glyph_write_active,
                  glyph_address, display_offset, display_enabled, cursor_enabled,
                  blink_enabled, increment_dir, bus_eight_bit, two_line, tall_font,
                  output ready);
endinterface

// ===== rtl/core/char_lcd_controller_core.sv =====
// Character LCD controller core.
// A result passes the DDRAM read register, then the output register, which waits while a result is held.
// No new item is accepted until the current result is loaded; the display memory read sets this.
// Clear takes effect by dropping all the per-entry written flags at once.
// Reset (rst_ni low, async): pointers and shift zero, all mode flags set,
// display memory reads as all zero.
module char_lcd_controller_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  clcd_in_if.sink    in_i,
  clcd_out_if.source out_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state_q, state_d;
  logic acc;
  logic load;

  // Controller registers
  logic [clcd_pkg::DdrAw-1:0]  ddptr_q, ddptr_d;
  logic [clcd_pkg::CgrAw-1:0]  cgptr_q, cgptr_d;
  logic                        cgsel_q, cgsel_d;
  logic [clcd_pkg::ShiftW-1:0] shift_q, shift_d;
  logic disp_q, disp_d, curs_q, curs_d, blink_q, blink_d, inc_q, inc_d;
  logic eight_q, eight_d, two_q, two_d, tall_q, tall_d;
  logic is_read_q;

  // Output register
  logic                        out_vld_q, out_vld_d;
  logic [clcd_pkg::DataW-1:0]  char_q;
  logic [clcd_pkg::DdrAw-1:0]  o_ddptr_q;
  logic [clcd_pkg::CgrAw-1:0]  o_cgptr_q;
  logic                        o_cgsel_q;
  logic [clcd_pkg::ShiftW-1:0] o_shift_q;
  logic o_disp_q, o_curs_q, o_blink_q, o_inc_q, o_eight_q, o_two_q, o_tall_q;

  clcd_pkg::ddr_req_t         ddr_req;
  logic [clcd_pkg::DataW-1:0] rd_data;
  logic [clcd_pkg::DdrAw-1:0] cell_lin;
  logic [clcd_pkg::DdrAw-1:0] ddptr_step;

  assign in_i.ready = (state_q == ST_IDLE);
  assign acc        = in_i.valid && in_i.ready;
  assign load       = (state_q == ST_BUSY) && (!out_vld_q || out_o.ready);

  // Cell read address: row base plus column, shift applied within the 64-entry line
  assign cell_lin   = clcd_pkg::row_base(in_i.cell_row) + {2'b00, in_i.cell_col};
  assign ddptr_step = inc_q ? 7'd1 : 7'h7f;

  // Item decode and state update
  always_comb begin
    ddptr_d = ddptr_q;
    cgptr_d = cgptr_q;
    cgsel_d = cgsel_q;
    shift_d = shift_q;
    disp_d  = disp_q;
    curs_d  = curs_q;
    blink_d = blink_q;
    inc_d   = inc_q;
    eight_d = eight_q;
    two_d   = two_q;
    tall_d  = tall_q;

    ddr_req.clr     = 1'b0;
    ddr_req.wr_en   = 1'b0;
    ddr_req.wr_addr = ddptr_q;
    ddr_req.wr_data = in_i.value;
    ddr_req.rd_en   = 1'b0;
    ddr_req.rd_addr = {cell_lin[6], cell_lin[5:0] + shift_q};

    if (acc) begin
      unique case (in_i.mode)
        clcd_pkg::MODE_DATA: begin
          if (cgsel_q) begin
            cgptr_d = cgptr_q + 6'd1;
          end else begin
            ddr_req.wr_en = 1'b1;
            ddptr_d       = ddptr_q + ddptr_step;
          end
        end
        clcd_pkg::MODE_CMD: begin
          priority if (in_i.value[clcd_pkg::CMD_SET_DDRAM]) begin
            ddptr_d = in_i.value[6:0];
            cgsel_d = 1'b0;
          end else if (in_i.value[clcd_pkg::CMD_SET_CGRAM]) begin
            cgptr_d = in_i.value[5:0];
            cgsel_d = 1'b1;
          end else if (in_i.value[clcd_pkg::CMD_FUNC_SET]) begin
            eight_d = in_i.value[4];
            two_d   = in_i.value[3];
            tall_d  = in_i.value[2];
          end else if (in_i.value[clcd_pkg::CMD_SHIFT]) begin
            cgsel_d = 1'b0;
            if (in_i.value[3]) begin
              shift_d = in_i.value[2] ? shift_q + 6'd1 : shift_q - 6'd1;
            end else begin
              ddptr_d = in_i.value[2] ? ddptr_q + 7'd1 : ddptr_q - 7'd1;
            end
          end else if (in_i.value[clcd_pkg::CMD_DISP_CTRL]) begin
            disp_d  = in_i.value[2];
            curs_d  = in_i.value[1];
            blink_d = in_i.value[0];
          end else if (in_i.value[clcd_pkg::CMD_ENTRY]) begin
            inc_d = in_i.value[1];
          end else if (in_i.value[clcd_pkg::CMD_HOME]) begin
            cgsel_d = 1'b0;
            ddptr_d = '0;
            shift_d = '0;
          end else if (in_i.value[clcd_pkg::CMD_CLEAR]) begin
            ddr_req.clr = 1'b1;
            cgsel_d     = 1'b0;
            ddptr_d     = '0;
            shift_d     = '0;
          end else begin
            // zero command: no effect
          end
        end
        clcd_pkg::MODE_READ: begin
          ddr_req.rd_en = 1'b1;
        end
        default: begin
          // unused mode: flags only
        end
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    out_vld_d = out_vld_q;
    if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: if (acc) state_d = ST_BUSY;
      ST_BUSY: begin
        if (load) begin
          state_d   = ST_IDLE;
          out_vld_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      is_read_q <= 1'b0;
      ddptr_q   <= '0;
      cgptr_q   <= '0;
      cgsel_q   <= 1'b0;
      shift_q   <= '0;
      disp_q    <= 1'b1;
      curs_q    <= 1'b1;
      blink_q   <= 1'b1;
      inc_q     <= 1'b1;
      eight_q   <= 1'b1;
      two_q     <= 1'b1;
      tall_q    <= 1'b1;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      if (acc) begin
        is_read_q <= (in_i.mode == clcd_pkg::MODE_READ);
      end
      ddptr_q <= ddptr_d;
      cgptr_q <= cgptr_d;
      cgsel_q <= cgsel_d;
      shift_q <= shift_d;
      disp_q  <= disp_d;
      curs_q  <= curs_d;
      blink_q <= blink_d;
      inc_q   <= inc_d;
      eight_q <= eight_d;
      two_q   <= two_d;
      tall_q  <= tall_d;
    end
  end

  // Result beat payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q    <= is_read_q ? rd_data : '0;
      o_ddptr_q <= ddptr_q;
      o_cgptr_q <= cgptr_q;
      o_cgsel_q <= cgsel_q;
      o_shift_q <= shift_q;
      o_disp_q  <= disp_q;
      o_curs_q  <= curs_q;
      o_blink_q <= blink_q;
      o_inc_q   <= inc_q;
      o_eight_q <= eight_q;
      o_two_q   <= two_q;
      o_tall_q  <= tall_q;
    end
  end

  clcd_ddram u_ddram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ddr_req),
    .rd_data_o (rd_data)
  );

  assign out_o.valid              = out_vld_q;
  assign out_o.cell_char          = char_q;
  assign out_o.address_counter    = o_ddptr_q;
  assign out_o.glyph_write_active = o_cgsel_q;
  assign out_o.glyph_address      = o_cgptr_q;
  assign out_o.display_offset     = o_shift_q;
  assign out_o.display_enabled    = o_disp_q;
  assign out_o.cursor_enabled     = o_curs_q;
  assign out_o.blink_enabled      = o_blink_q;
  assign out_o.increment_dir      = o_inc_q;
  assign out_o.bus_eight_bit      = o_eight_q;
  assign out_o.two_line           = o_two_q;
  assign out_o.tall_font          = o_tall_q;

`ifndef SYNTHESIS
  // One item in flight: an accepted beat closes the input until its result is loaded
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> !in_i.ready)
    else $error("input accepted while an item is in flight");

  // Memory reads are only issued for accepted cell reads
  a_rd_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ddr_req.rd_en |-> (acc && in_i.mode == clcd_pkg::MODE_READ))
    else $error("display read without accepted cell read");

  // Clear and write never hit the memory together
  a_clr_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ddr_req.clr && ddr_req.wr_en))
    else $error("clear and write in the same cycle");

  // Leaving busy always leaves a result beat behind
  a_busy_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BUSY && state_d == ST_IDLE) |=> out_vld_q)
    else $error("item finished without a result");
`endif

endmodule

// ===== rtl/core/clcd_ddram.sv =====
module clcd_ddram (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  clcd_pkg::ddr_req_t          req_i,
  output logic [clcd_pkg::DataW-1:0]  rd_data_o
);

  logic [clcd_pkg::DataW-1:0]    mem_q [clcd_pkg::DdrDepth];
  logic [clcd_pkg::DdrDepth-1:0] vld_q;
  logic [clcd_pkg::DataW-1:0]    rd_data_q;
  logic                          rd_vld_q;

  // Storage array, no reset
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  // Per-entry written flags; clear drops them all at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  // Entries not written since the last clear read as zero
  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule
